>>> src/rfgb_pkg.sv
package rfgb_pkg;

   // Field widths
   localparam int SAMPLE_BITS    = 16;
   localparam int ROW_BITS       = 12;
   localparam int WEIGHT_BITS    = 16;
   localparam int FRAC_BITS      = 15;
   localparam int MAX_ROWS       = 4096;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 16;

   // Queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // Blend datapath widths
   localparam int PROD_BITS  = SAMPLE_BITS + WEIGHT_BITS + 1;
   localparam int SUM_BITS   = PROD_BITS + 1;
   localparam int ROUND_BITS = SUM_BITS + 1;
   localparam int QUOT_BITS  = ROUND_BITS - FRAC_BITS;

   // Register reset values
   localparam logic [WEIGHT_BITS-1:0]        FULL_WEIGHT_RESET = 16'h8000;
   localparam logic signed [SAMPLE_BITS-1:0] BAD_RESET         = 16'sh8000;
   localparam logic signed [SAMPLE_BITS-1:0] MISSING_RESET     = 16'sh8001;

   typedef enum logic [1:0] {
      KIND_SOUTH = 2'd0,
      KIND_NORTH = 2'd1,
      KIND_BLEND = 2'd2
   } kind_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_ZONE_START    = 3'd0,
      CSR_ZONE_END      = 3'd1,
      CSR_FULL_WEIGHT   = 3'd2,
      CSR_WEIGHT_STEP   = 3'd3,
      CSR_SOUTH_BAD     = 3'd4,
      CSR_SOUTH_MISSING = 3'd5,
      CSR_NORTH_BAD     = 3'd6,
      CSR_NORTH_MISSING = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [ROW_BITS-1:0]           zone_start_row;
      logic [ROW_BITS-1:0]           zone_end_row;
      logic [WEIGHT_BITS-1:0]        full_weight;
      logic [WEIGHT_BITS-1:0]        weight_step;
      logic signed [SAMPLE_BITS-1:0] south_bad_value;
      logic signed [SAMPLE_BITS-1:0] south_missing_value;
      logic signed [SAMPLE_BITS-1:0] north_bad_value;
      logic signed [SAMPLE_BITS-1:0] north_missing_value;
   } cfg_type;

   // One classified sample waiting for the back end
   typedef struct packed {
      kind_type                      kind;
      logic signed [SAMPLE_BITS-1:0] south;
      logic signed [SAMPLE_BITS-1:0] north;
      logic [WEIGHT_BITS-1:0]        weight;
      logic [WEIGHT_BITS-1:0]        inv_weight;
   } item_type;

endpackage

>>> src/rfgb_front.sv
module rfgb_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic signed [rfgb_pkg::SAMPLE_BITS-1:0] req_south_value,
   input  logic signed [rfgb_pkg::SAMPLE_BITS-1:0] req_north_value,
   input  logic                               req_end_of_row,
   input  logic                               req_end_of_plane,
   input  rfgb_pkg::cfg_type                  cfg,
   input  logic                               queue_full,
   output logic                               push,
   output rfgb_pkg::item_type                 push_item
);
   import rfgb_pkg::*;

   logic [ROW_BITS-1:0]    row_index_ff, row_index_in;
   logic [WEIGHT_BITS-1:0] row_weight_ff, row_weight_in;
   logic                   accept;
   logic                   zone_empty, north_flagged, south_flagged;
   logic [ROW_BITS:0]      row_plus;
   logic [ROW_BITS-1:0]    next_row;
   logic [WEIGHT_BITS:0]   weight_sum;
   logic [WEIGHT_BITS-1:0] weight;
   kind_type               kind;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;
   assign push      = accept;

   // Classify the sample by row position and sentinel codes
   always_comb begin
      zone_empty    = cfg.zone_start_row >= cfg.zone_end_row;
      north_flagged = (req_north_value == cfg.north_bad_value) ||
                      (req_north_value == cfg.north_missing_value);
      south_flagged = (req_south_value == cfg.south_bad_value) ||
                      (req_south_value == cfg.south_missing_value);
      kind = KIND_SOUTH;
      if (row_index_ff > cfg.zone_end_row) begin
         kind = KIND_NORTH;
      end else if (!zone_empty && row_index_ff >= cfg.zone_start_row) begin
         if (north_flagged) begin
            kind = KIND_SOUTH;
         end else if (south_flagged) begin
            kind = KIND_NORTH;
         end else begin
            kind = KIND_BLEND;
         end
      end
      // last zone row gets full weight, others are clipped to it
      if (row_index_ff == cfg.zone_end_row || row_weight_ff > cfg.full_weight) begin
         weight = cfg.full_weight;
      end else begin
         weight = row_weight_ff;
      end
   end

   always_comb begin
      push_item.kind       = kind;
      push_item.south      = req_south_value;
      push_item.north      = req_north_value;
      push_item.weight     = weight;
      push_item.inv_weight = cfg.full_weight - weight;
   end

   // Row counter and weight accumulator
   always_comb begin
      row_plus      = {1'b0, row_index_ff} + {{ROW_BITS{1'b0}}, 1'b1};
      weight_sum    = {1'b0, row_weight_ff} + {1'b0, cfg.weight_step};
      row_index_in  = row_index_ff;
      row_weight_in = row_weight_ff;
      if (req_end_of_plane) begin
         next_row = '0;
      end else if (int'(row_plus) >= MAX_ROWS) begin
         next_row = '0;
      end else begin
         next_row = row_plus[ROW_BITS-1:0];
      end
      if (accept && (req_end_of_row || req_end_of_plane)) begin
         row_index_in = next_row;
         if (next_row <= cfg.zone_start_row) begin
            row_weight_in = '0;
         end else if (weight_sum[WEIGHT_BITS]) begin
            row_weight_in = '1;
         end else begin
            row_weight_in = weight_sum[WEIGHT_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_index_ff  <= '0;
         row_weight_ff <= '0;
      end else begin
         row_index_ff  <= row_index_in;
         row_weight_ff <= row_weight_in;
      end
   end

endmodule

>>> src/rfgb_queue.sv
module rfgb_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  rfgb_pkg::item_type push_item,
   output logic               full,
   input  logic               pop,
   output logic               empty,
   output rfgb_pkg::item_type pop_item
);
   import rfgb_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);

   item_type          slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign full     = count_ff == DEPTH_CNT;
   assign empty    = count_ff == '0;
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_item = slot_ff[rd_ptr_ff];

   // Pointer and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

>>> src/rfgb_back.sv
module rfgb_back (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    queue_empty,
   input  rfgb_pkg::item_type                      pop_item,
   output logic                                    pop,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic signed [rfgb_pkg::SAMPLE_BITS-1:0] rsp_out_value,
   output logic [1:0]                              rsp_source_kind,
   output logic                                    rsp_saturated
);
   import rfgb_pkg::*;

   localparam logic signed [QUOT_BITS-1:0]  SAT_HI = QUOT_BITS'(2**(SAMPLE_BITS-1) - 1);
   localparam logic signed [QUOT_BITS-1:0]  SAT_LO = ~SAT_HI;
   localparam logic signed [ROUND_BITS-1:0] HALF   = ROUND_BITS'(2**(FRAC_BITS-1));

   // Multiply stage
   logic                          s1_valid_ff, s1_valid_in;
   kind_type                      s1_kind_ff;
   logic signed [SAMPLE_BITS-1:0] s1_pass_ff;
   logic signed [PROD_BITS-1:0]   s1_prod_s_ff, s1_prod_n_ff;
   logic signed [PROD_BITS-1:0]   s1_prod_s_in, s1_prod_n_in;
   logic                          s1_load;

   // Output stage
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] out_value_ff, out_value_in;
   kind_type                      kind_ff;
   logic                          saturated_ff, saturated_in;
   logic                          out_ready;

   logic signed [SUM_BITS-1:0]    sum;
   logic signed [ROUND_BITS-1:0]  rounded;
   logic signed [QUOT_BITS-1:0]   quot;

   assign out_ready   = !rsp_valid_ff || !rsp_stall;
   assign s1_load     = !s1_valid_ff || out_ready;
   assign pop         = s1_load && !queue_empty;
   assign s1_valid_in = pop ? 1'b1 : (out_ready ? 1'b0 : s1_valid_ff);

   // Weighted products: samples sign-extended, weights zero-extended
   always_comb begin
      s1_prod_s_in = PROD_BITS'(pop_item.south) *
                     PROD_BITS'($signed({1'b0, pop_item.inv_weight}));
      s1_prod_n_in = PROD_BITS'(pop_item.north) *
                     PROD_BITS'($signed({1'b0, pop_item.weight}));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         s1_kind_ff   <= pop_item.kind;
         s1_pass_ff   <= (pop_item.kind == KIND_NORTH) ? pop_item.north : pop_item.south;
         s1_prod_s_ff <= s1_prod_s_in;
         s1_prod_n_ff <= s1_prod_n_in;
      end
   end

   // Sum, round half up, saturate
   always_comb begin
      sum          = SUM_BITS'(s1_prod_s_ff) + SUM_BITS'(s1_prod_n_ff);
      rounded      = ROUND_BITS'(sum) + HALF;
      quot         = $signed(rounded[ROUND_BITS-1:FRAC_BITS]);
      out_value_in = s1_pass_ff;
      saturated_in = 1'b0;
      if (s1_kind_ff == KIND_BLEND) begin
         if (quot > SAT_HI) begin
            out_value_in = SAT_HI[SAMPLE_BITS-1:0];
            saturated_in = 1'b1;
         end else if (quot < SAT_LO) begin
            out_value_in = SAT_LO[SAMPLE_BITS-1:0];
            saturated_in = 1'b1;
         end else begin
            out_value_in = quot[SAMPLE_BITS-1:0];
         end
      end
      rsp_valid_in = out_ready ? s1_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && s1_valid_ff) begin
         out_value_ff <= out_value_in;
         kind_ff      <= s1_kind_ff;
         saturated_ff <= saturated_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_value   = out_value_ff;
   assign rsp_source_kind = kind_ff;
   assign rsp_saturated   = saturated_ff;

endmodule

>>> src/row_feathered_grid_blend.sv
// A req beat passes the queue entry, the multiply register and the sum/saturate register
// before rsp_valid goes high for it.
// Throughput: one beat per cycle unless req_stall is high; the front end classifies and
// updates the row counter in the accept cycle, the back end multiplies and rounds in two stages.
// Under rsp_stall four beats fill the back end and the 2-entry queue before req_stall rises.
// Reset (synchronous, active high) clears row counter, weight, queue and valids, loads reg defaults.
module row_feathered_grid_blend (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic signed [rfgb_pkg::SAMPLE_BITS-1:0] req_south_value,
   input  logic signed [rfgb_pkg::SAMPLE_BITS-1:0] req_north_value,
   input  logic                                    req_end_of_row,
   input  logic                                    req_end_of_plane,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic signed [rfgb_pkg::SAMPLE_BITS-1:0] rsp_out_value,
   output logic [1:0]                              rsp_source_kind,
   output logic                                    rsp_saturated,
   input  logic                                    csr_wr_en,
   input  logic [rfgb_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [rfgb_pkg::CSR_DATA_BITS-1:0]      csr_wdata
);
   import rfgb_pkg::*;

   cfg_type  cfg_ff;
   item_type push_item, pop_item;
   logic     push, pop, queue_full, queue_empty;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.zone_start_row      <= '0;
         cfg_ff.zone_end_row        <= '0;
         cfg_ff.full_weight         <= FULL_WEIGHT_RESET;
         cfg_ff.weight_step         <= '0;
         cfg_ff.south_bad_value     <= BAD_RESET;
         cfg_ff.south_missing_value <= MISSING_RESET;
         cfg_ff.north_bad_value     <= BAD_RESET;
         cfg_ff.north_missing_value <= MISSING_RESET;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_ZONE_START:    cfg_ff.zone_start_row      <= csr_wdata[ROW_BITS-1:0];
            CSR_ZONE_END:      cfg_ff.zone_end_row        <= csr_wdata[ROW_BITS-1:0];
            CSR_FULL_WEIGHT:   cfg_ff.full_weight         <= csr_wdata[WEIGHT_BITS-1:0];
            CSR_WEIGHT_STEP:   cfg_ff.weight_step         <= csr_wdata[WEIGHT_BITS-1:0];
            CSR_SOUTH_BAD:     cfg_ff.south_bad_value     <= $signed(csr_wdata[SAMPLE_BITS-1:0]);
            CSR_SOUTH_MISSING: cfg_ff.south_missing_value <= $signed(csr_wdata[SAMPLE_BITS-1:0]);
            CSR_NORTH_BAD:     cfg_ff.north_bad_value     <= $signed(csr_wdata[SAMPLE_BITS-1:0]);
            CSR_NORTH_MISSING: cfg_ff.north_missing_value <= $signed(csr_wdata[SAMPLE_BITS-1:0]);
            default: begin
            end
         endcase
      end
   end

   rfgb_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_south_value  (req_south_value),
      .req_north_value  (req_north_value),
      .req_end_of_row   (req_end_of_row),
      .req_end_of_plane (req_end_of_plane),
      .cfg              (cfg_ff),
      .queue_full       (queue_full),
      .push             (push),
      .push_item        (push_item)
   );

   rfgb_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (queue_full),
      .pop       (pop),
      .empty     (queue_empty),
      .pop_item  (pop_item)
   );

   rfgb_back u_back (
      .clock           (clock),
      .reset           (reset),
      .queue_empty     (queue_empty),
      .pop_item        (pop_item),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_value   (rsp_out_value),
      .rsp_source_kind (rsp_source_kind),
      .rsp_saturated   (rsp_saturated)
   );

endmodule
